// ===== rtl/core/tcce_pkg.sv =====
// Package with the shared types, sizes and character codes of the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

   // Screen geometry.
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STEP = 4;
   localparam int CELLS    = ROWS * COLUMNS;

   // Field and storage widths.
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int PH_W    = (TAB_STEP > 2) ? $clog2(TAB_STEP) : 1;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;
   localparam int CMD_W   = 2;
   localparam int RIDX_W  = 11;
   localparam int CSR_IDX_W = 1;

   // Tab phase of the last column, used when backspace wraps to the previous row.
   localparam int BS_WRAP_PH = (COLUMNS - 1) % TAB_STEP;

   // Reset value of both attribute registers.
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ATTR = 1'd1;

   // Request payload.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] char_code;
      logic [ATTR_W-1:0] clear_attribute;
      logic [RIDX_W-1:0] read_index;
   } tcce_req_type;

   // Response payload.
   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } tcce_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic put_step;
      logic clear_run;
      logic move_run;
      logic fill_run;
      logic read_issue;
      logic read_take;
      logic rsp_load;
   } tcce_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] in_cmd;
      logic             in_read_ok;
      logic             need_scroll;
      logic             move_last;
      logic             fill_last;
      logic             rsp_free;
   } tcce_status_type;

endpackage

// ===== rtl/core/tcce_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/tcce_ctrl.sv =====
// Controller state machine that sequences put, clear, scroll and read operations.
`timescale 1ns / 1ps

module tcce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tcce_pkg::tcce_status_type status,
   output tcce_pkg::tcce_cmd_type    command
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PUT   = 8'b0000_0010,
      S_MOVE  = 8'b0000_0100,
      S_FILL  = 8'b0000_1000,
      S_CLEAR = 8'b0001_0000,
      S_READ  = 8'b0010_0000,
      S_RDCAP = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_xfer;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      command  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               command.capture = 1'b1;
               case (status.in_cmd)
                  tcce_pkg::CMD_PUT:   state_in = S_PUT;
                  tcce_pkg::CMD_CLEAR: state_in = S_CLEAR;
                  tcce_pkg::CMD_READ:  state_in = status.in_read_ok ? S_READ : S_RESP;
                  default:             state_in = S_RESP;
               endcase
            end
         end
         S_PUT: begin
            command.put_step = 1'b1;
            state_in = status.need_scroll ? S_MOVE : S_RESP;
         end
         S_MOVE: begin
            command.move_run = 1'b1;
            if (status.move_last) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            command.fill_run = 1'b1;
            if (status.fill_last) begin
               state_in = S_RESP;
            end
         end
         S_CLEAR: begin
            command.clear_run = 1'b1;
            if (status.fill_last) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            command.read_issue = 1'b1;
            state_in = S_RDCAP;
         end
         S_RDCAP: begin
            command.read_take = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (status.rsp_free) begin
               command.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted request always starts an operation.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("accepted request did not start an operation");

   // The scroll copy is always followed by the bottom row fill.
   a_move_then_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && status.move_last) |=> (state_ff == S_FILL))
      else $error("scroll copy did not hand over to the row fill");

   // A finished operation waits while the response register is still occupied.
   a_resp_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !status.rsp_free) |=> (state_ff == S_RESP))
      else $error("response loaded while the response register was occupied");

endmodule

// ===== rtl/core/tcce_dp.sv =====
// Datapath with cursor, attribute registers, sweep counter, memory port muxing and response.
`timescale 1ns / 1ps

module tcce_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcce_pkg::tcce_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tcce_pkg::tcce_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcce_pkg::ATTR_W-1:0]          csr_wdata,
   input  tcce_pkg::tcce_cmd_type               command,
   output tcce_pkg::tcce_status_type            status,
   output logic                                 ram_wr_en,
   output logic [tcce_pkg::ADDR_W-1:0]          ram_wr_addr,
   output logic [tcce_pkg::CELL_W-1:0]          ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [tcce_pkg::ADDR_W-1:0]          ram_rd_addr,
   input  logic [tcce_pkg::CELL_W-1:0]          ram_rd_data
);

   tcce_pkg::tcce_req_type              req_ff;
   logic [tcce_pkg::COL_W-1:0]          cursor_x_ff;
   logic [tcce_pkg::ROW_W-1:0]          cursor_y_ff;
   logic [tcce_pkg::PH_W-1:0]           phase_ff;
   logic [tcce_pkg::ATTR_W-1:0]         text_attr_ff;
   logic [tcce_pkg::ATTR_W-1:0]         scroll_attr_ff;
   logic [tcce_pkg::ADDR_W-1:0]         cnt_ff;
   logic [tcce_pkg::CELL_W-1:0]         cell_ff;
   logic                                scrolled_ff;
   logic                                rsp_valid_ff;
   tcce_pkg::tcce_rsp_type              rsp_ff;

   logic [tcce_pkg::COL_W:0]            col_calc;
   logic [tcce_pkg::ROW_W:0]            row_calc;
   logic [tcce_pkg::PH_W-1:0]           ph_calc;
   logic                                put_wr;
   logic [tcce_pkg::COL_W-1:0]          wr_col;
   logic [tcce_pkg::ROW_W-1:0]          wr_row;
   logic [tcce_pkg::CHAR_W-1:0]         wr_char;
   logic                                put_scroll;
   logic [tcce_pkg::ADDR_W-1:0]         put_addr;

   // Configuration registers are always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff   <= tcce_pkg::ATTR_RESET;
         scroll_attr_ff <= tcce_pkg::ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcce_pkg::CSR_TEXT_ATTR:   text_attr_ff   <= csr_wdata;
            tcce_pkg::CSR_SCROLL_ATTR: scroll_attr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Put-character cursor arithmetic; the tab phase tracks the column modulo the tab step.
   always_comb begin
      col_calc = {1'b0, cursor_x_ff};
      row_calc = {1'b0, cursor_y_ff};
      ph_calc  = phase_ff;
      put_wr   = 1'b0;
      wr_col   = cursor_x_ff;
      wr_row   = cursor_y_ff;
      wr_char  = req_ff.char_code;
      case (req_ff.char_code)
         tcce_pkg::CH_BS: begin
            if (cursor_x_ff != '0) begin
               col_calc = col_calc - 1'b1;
               wr_col   = cursor_x_ff - 1'b1;
               wr_char  = tcce_pkg::CH_BLANK;
               put_wr   = 1'b1;
               ph_calc  = (phase_ff == '0) ? tcce_pkg::PH_W'(tcce_pkg::TAB_STEP - 1)
                                           : phase_ff - 1'b1;
            end else if (cursor_y_ff != '0) begin
               row_calc = row_calc - 1'b1;
               col_calc = (tcce_pkg::COL_W + 1)'(tcce_pkg::COLUMNS - 1);
               wr_col   = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
               wr_row   = cursor_y_ff - 1'b1;
               wr_char  = tcce_pkg::CH_BLANK;
               put_wr   = 1'b1;
               ph_calc  = tcce_pkg::PH_W'(tcce_pkg::BS_WRAP_PH);
            end
         end
         tcce_pkg::CH_TAB: begin
            col_calc = col_calc + (tcce_pkg::COL_W + 1)'(tcce_pkg::TAB_STEP)
                     - (tcce_pkg::COL_W + 1)'(phase_ff);
            ph_calc  = '0;
         end
         tcce_pkg::CH_CR: begin
            col_calc = '0;
            ph_calc  = '0;
         end
         tcce_pkg::CH_LF: begin
            col_calc = '0;
            row_calc = row_calc + 1'b1;
            ph_calc  = '0;
         end
         default: begin
            if (req_ff.char_code >= tcce_pkg::CH_BLANK) begin
               put_wr   = 1'b1;
               col_calc = col_calc + 1'b1;
               ph_calc  = (phase_ff == tcce_pkg::PH_W'(tcce_pkg::TAB_STEP - 1)) ? '0
                                                                         : phase_ff + 1'b1;
            end
         end
      endcase
      // Wrap at the end of the line.
      if (col_calc >= (tcce_pkg::COL_W + 1)'(tcce_pkg::COLUMNS)) begin
         col_calc = '0;
         row_calc = row_calc + 1'b1;
         ph_calc  = '0;
      end
   end

   assign put_scroll = (row_calc >= (tcce_pkg::ROW_W + 1)'(tcce_pkg::ROWS));
   assign put_addr   = tcce_pkg::ADDR_W'(wr_row) * tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS)
                     + tcce_pkg::ADDR_W'(wr_col);

   // Cursor, request and sweep counter registers; the counter holds on the last copy step
   // so that the bottom-row fill starts at the first cell of that row.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         phase_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         if (command.capture) begin
            cnt_ff <= '0;
         end else if (command.clear_run || command.fill_run
                      || (command.move_run && !status.move_last)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (command.put_step) begin
            cursor_x_ff <= col_calc[tcce_pkg::COL_W-1:0];
            cursor_y_ff <= put_scroll ? tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)
                                      : row_calc[tcce_pkg::ROW_W-1:0];
            phase_ff    <= ph_calc;
         end else if (command.clear_run) begin
            cursor_x_ff <= '0;
            cursor_y_ff <= '0;
            phase_ff    <= '0;
         end
      end
   end

   // Request payload and per-item result fields.
   always_ff @(posedge clock) begin
      if (command.capture) begin
         req_ff      <= req_data;
         cell_ff     <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         if (command.read_take) begin
            cell_ff <= ram_rd_data;
         end
         if (command.put_step) begin
            scrolled_ff <= put_scroll;
         end
      end
   end

   // Memory port selection: the scroll copy reads one row ahead of the cell it writes.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff;
      ram_wr_data = {req_ff.clear_attribute, tcce_pkg::CH_BLANK};
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff + tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS);
      if (command.put_step) begin
         ram_wr_en   = put_wr;
         ram_wr_addr = put_addr;
         ram_wr_data = {text_attr_ff, wr_char};
      end else if (command.move_run) begin
         ram_wr_en   = (cnt_ff != '0);
         ram_wr_addr = cnt_ff - 1'b1;
         ram_wr_data = ram_rd_data;
         ram_rd_en   = !status.move_last;
      end else if (command.fill_run) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = {scroll_attr_ff, tcce_pkg::CH_BLANK};
      end else if (command.clear_run) begin
         ram_wr_en   = 1'b1;
      end else if (command.read_issue) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = req_ff.read_index[tcce_pkg::ADDR_W-1:0];
      end
   end

   // Response register parts the result side from the working side.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (command.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (command.rsp_load) begin
         rsp_ff.cursor_col <= cursor_x_ff;
         rsp_ff.cursor_row <= cursor_y_ff;
         rsp_ff.cell_data  <= cell_ff;
         rsp_ff.scrolled   <= scrolled_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status toward the controller.
   assign status.in_cmd      = req_data.cmd;
   assign status.in_read_ok  = (req_data.read_index < tcce_pkg::RIDX_W'(tcce_pkg::CELLS));
   assign status.need_scroll = put_scroll;
   assign status.move_last   = (cnt_ff == tcce_pkg::ADDR_W'(tcce_pkg::CELLS - tcce_pkg::COLUMNS));
   assign status.fill_last   = (cnt_ff == tcce_pkg::ADDR_W'(tcce_pkg::CELLS - 1));
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   // The scroll copy never reads the cell it is writing.
   a_move_no_collision: assert property (@(posedge clock) disable iff (reset)
      (command.move_run && ram_wr_en && ram_rd_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("scroll copy read and write hit the same cell");

   // The cursor row stays on the screen and its tab phase matches the column.
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_y_ff < tcce_pkg::ROW_W'(tcce_pkg::ROWS))
      && (tcce_pkg::COL_W'(phase_ff) == tcce_pkg::COL_W'(cursor_x_ff % tcce_pkg::TAB_STEP)))
      else $error("cursor row or tab phase out of step");

   // A response that reports a scroll leaves the cursor on the bottom row.
   a_scroll_bottom_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.scrolled)
      |-> (rsp_ff.cursor_row == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)))
      else $error("scroll reported with cursor off the bottom row");

endmodule

// ===== rtl/core/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine: controller, datapath and screen memory.
// An unused command or a read past the end of the screen goes straight to the response. A put
// that scrolls copies rows up through the screen memory and then blanks the bottom row; a
// clear fills every cell. Requests are taken one at a time: a new request is stalled until
// the response to the previous one has been loaded.
// Reset clears the cursor and sets both attributes to 0x0F; the screen memory is not
// cleared and holds no defined content until a clear command is run.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tcce_pkg::tcce_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tcce_pkg::tcce_rsp_type           rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcce_pkg::ATTR_W-1:0]      csr_wdata
);

   tcce_pkg::tcce_cmd_type         command;
   tcce_pkg::tcce_status_type      status;
   logic                           ram_wr_en;
   logic [tcce_pkg::ADDR_W-1:0]    ram_wr_addr;
   logic [tcce_pkg::CELL_W-1:0]    ram_wr_data;
   logic                           ram_rd_en;
   logic [tcce_pkg::ADDR_W-1:0]    ram_rd_addr;
   logic [tcce_pkg::CELL_W-1:0]    ram_rd_data;

   // Operation sequencing.
   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .command   (command)
   );

   // Cursor, registers and memory port control.
   tcce_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .command     (command),
      .status      (status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Screen cell storage.
   tcce_ram #(
      .WIDTH (tcce_pkg::CELL_W),
      .DEPTH (tcce_pkg::CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== verif/tb_text_console_cursor_engine_unit.sv =====
// Self-checking testbench for the text console cursor engine: directed and random console traffic.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_unit;

   // Command code that the block leaves unused.
   localparam logic [tcce_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT     = 5_000_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 16;
   localparam int READ_SPAN       = 2048;
   localparam int IDLE_PCT        = 19;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   tcce_pkg::tcce_req_type         req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   tcce_pkg::tcce_rsp_type         rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tcce_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tcce_pkg::ATTR_W-1:0]    csr_wdata = '0;

   // Predicted screen, cursor and attribute registers.
   logic [tcce_pkg::CELL_W-1:0] screen_q [tcce_pkg::CELLS];
   int                          cur_col;
   int                          cur_row;
   logic [tcce_pkg::ATTR_W-1:0] text_attr;
   logic [tcce_pkg::ATTR_W-1:0] fill_attr;

   // Responses still owed by the block, oldest first.
   tcce_pkg::tcce_rsp_type expected_rsp_q [$];

   int     idle_pct      = IDLE_PCT;
   int     hold_requests = 0;
   int     hold_seen     = 0;
   int     hold_left     = 0;
   int     items_sent    = 0;
   int     rsp_count     = 0;
   int     error_count   = 0;
   longint cycle_count   = 0;

   text_console_cursor_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Applies one command to the predicted console and returns the response it should give.
   function automatic tcce_pkg::tcce_rsp_type console_step(input tcce_pkg::tcce_req_type item);
      tcce_pkg::tcce_rsp_type rsp;
      rsp = '0;
      case (item.cmd)
         tcce_pkg::CMD_PUT: begin
            if (item.char_code == tcce_pkg::CH_BS) begin
               // Backspace at column 0 steps back onto the last column of the row above.
               if (cur_col != 0) begin
                  cur_col--;
                  screen_q[cur_row * tcce_pkg::COLUMNS + cur_col] =
                     {text_attr, tcce_pkg::CH_BLANK};
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = tcce_pkg::COLUMNS - 1;
                  screen_q[cur_row * tcce_pkg::COLUMNS + cur_col] =
                     {text_attr, tcce_pkg::CH_BLANK};
               end
            end else if (item.char_code == tcce_pkg::CH_TAB) begin
               cur_col = (cur_col / tcce_pkg::TAB_STEP + 1) * tcce_pkg::TAB_STEP;
            end else if (item.char_code == tcce_pkg::CH_CR) begin
               cur_col = 0;
            end else if (item.char_code == tcce_pkg::CH_LF) begin
               cur_col = 0;
               cur_row++;
            end else if (item.char_code >= tcce_pkg::CH_BLANK) begin
               screen_q[cur_row * tcce_pkg::COLUMNS + cur_col] = {text_attr, item.char_code};
               cur_col++;
            end
            if (cur_col >= tcce_pkg::COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            // Past the last row the screen moves up one line and the bottom row is blanked.
            if (cur_row >= tcce_pkg::ROWS) begin
               for (int i = 0; i < tcce_pkg::CELLS - tcce_pkg::COLUMNS; i++)
                  screen_q[i] = screen_q[i + tcce_pkg::COLUMNS];
               for (int i = tcce_pkg::CELLS - tcce_pkg::COLUMNS; i < tcce_pkg::CELLS; i++)
                  screen_q[i] = {fill_attr, tcce_pkg::CH_BLANK};
               cur_row = tcce_pkg::ROWS - 1;
               rsp.scrolled = 1'b1;
            end
         end
         tcce_pkg::CMD_CLEAR: begin
            foreach (screen_q[i]) screen_q[i] = {item.clear_attribute, tcce_pkg::CH_BLANK};
            cur_col = 0;
            cur_row = 0;
         end
         tcce_pkg::CMD_READ: begin
            if (item.read_index < tcce_pkg::CELLS) rsp.cell_data = screen_q[item.read_index];
         end
         default: ;
      endcase
      rsp.cursor_col = cur_col[tcce_pkg::COL_W-1:0];
      rsp.cursor_row = cur_row[tcce_pkg::ROW_W-1:0];
      return rsp;
   endfunction

   // Offers one command, with the fields it does not use random, and predicts it on transfer.
   task automatic send_command(input logic [tcce_pkg::CMD_W-1:0] cmd, input int value);
      tcce_pkg::tcce_req_type item;
      item.cmd             = cmd;
      item.char_code       = tcce_pkg::CHAR_W'($urandom_range(255));
      item.clear_attribute = tcce_pkg::ATTR_W'($urandom_range(255));
      item.read_index      = tcce_pkg::RIDX_W'($urandom_range(READ_SPAN - 1));
      case (cmd)
         tcce_pkg::CMD_PUT:   item.char_code       = tcce_pkg::CHAR_W'(value);
         tcce_pkg::CMD_CLEAR: item.clear_attribute = tcce_pkg::ATTR_W'(value);
         tcce_pkg::CMD_READ:  item.read_index      = tcce_pkg::RIDX_W'(value);
         default: ;
      endcase
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp_q.push_back(console_step(item));
      items_sent++;
   endtask

   // Drops the request valid and waits until every response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [tcce_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [tcce_pkg::ATTR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == tcce_pkg::CSR_TEXT_ATTR) text_attr = value;
      else fill_attr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: random stalls, plus a long hold-off whenever a test asks for one.
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Compares each response transfer with the oldest prediction.
   always @(posedge clock) begin : check_responses
      tcce_pkg::tcce_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            report_error($sformatf("response %0d arrived with none expected", rsp_count));
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.cursor_col !== want.cursor_col)
               report_error($sformatf("response %0d cursor_col %0d, expected %0d",
                                      rsp_count, rsp_data.cursor_col, want.cursor_col));
            if (rsp_data.cursor_row !== want.cursor_row)
               report_error($sformatf("response %0d cursor_row %0d, expected %0d",
                                      rsp_count, rsp_data.cursor_row, want.cursor_row));
            if (rsp_data.cell_data !== want.cell_data)
               report_error($sformatf("response %0d cell_data %h, expected %h",
                                      rsp_count, rsp_data.cell_data, want.cell_data));
            if (rsp_data.scrolled !== want.scrolled)
               report_error($sformatf("response %0d scrolled %b, expected %b",
                                      rsp_count, rsp_data.scrolled, want.scrolled));
         end
      end
   end

   // Clear the screen, then read its first and last cells and indexes past the end.
   task automatic test_clear_and_read();
      send_command(tcce_pkg::CMD_CLEAR, 8'hA5);
      send_command(tcce_pkg::CMD_READ, 0);
      send_command(tcce_pkg::CMD_READ, tcce_pkg::CELLS - 1);
      send_command(tcce_pkg::CMD_READ, tcce_pkg::CELLS);
      send_command(tcce_pkg::CMD_READ, READ_SPAN - 1);
   endtask

   // Printable extremes, every control byte case, wrap and tab past the line end.
   task automatic test_put_characters();
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BLANK);
      send_command(tcce_pkg::CMD_PUT, 8'hFF);
      send_command(tcce_pkg::CMD_PUT, 8'h7E);
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BS);
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB);
      send_command(tcce_pkg::CMD_PUT, 8'h00);
      send_command(tcce_pkg::CMD_PUT, 8'h1F);
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_CR);
      // Backspace at the home position does nothing.
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BS);
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_LF);
      // Backspace at column 0 moves up to the last column of row 0.
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BS);
      // A character in the last column wraps the cursor to the next row.
      send_command(tcce_pkg::CMD_PUT, 8'h41);
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BS);
      // A tab from the last column wraps as well.
      send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB);
      send_command(tcce_pkg::CMD_READ, tcce_pkg::COLUMNS - 1);
      send_command(tcce_pkg::CMD_READ, 1);
   endtask

   task automatic test_unused_command();
      send_command(CMD_UNUSED, 0);
      send_command(CMD_UNUSED, 0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_response_hold_off();
      hold_requests++;
      repeat (12) send_command(tcce_pkg::CMD_PUT, $urandom_range(8'h20, 8'hFF));
      send_command(tcce_pkg::CMD_READ, cur_row * tcce_pkg::COLUMNS);
   endtask

   // Random console traffic, built mostly from lines of text and runs of control bytes.
   task automatic run_random_traffic(input int count);
      int                          stop_at;
      int                          kind;
      logic [tcce_pkg::CHAR_W-1:0] ch;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 48) begin
            // A line of text with an occasional control byte, closed by CR and LF.
            repeat ($urandom_range(1, 40)) begin
               if ($urandom_range(9) == 0) ch = tcce_pkg::CHAR_W'($urandom_range(8'h1F));
               else ch = tcce_pkg::CHAR_W'($urandom_range(8'h20, 8'hFF));
               send_command(tcce_pkg::CMD_PUT, ch);
            end
            send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_CR);
            send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_LF);
         end else if (kind < 60) begin
            // A run of line feeds moves the cursor down and scrolls once it passes the bottom row.
            repeat ($urandom_range(4, 20)) send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_LF);
         end else if (kind < 82) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(6) == 0)
                  send_command(tcce_pkg::CMD_READ,
                               $urandom_range(tcce_pkg::CELLS, READ_SPAN - 1));
               else
                  send_command(tcce_pkg::CMD_READ, $urandom_range(tcce_pkg::CELLS - 1));
            end
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 25)) send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB);
         end else if (kind < 94) begin
            repeat ($urandom_range(1, 40)) send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BS);
         end else if (kind < 98) begin
            if ($urandom_range(1) == 0) send_command(CMD_UNUSED, 0);
            else send_command(tcce_pkg::CMD_PUT, $urandom_range(8'h1F));
         end else begin
            send_command(tcce_pkg::CMD_CLEAR, $urandom_range(255));
         end
      end
   endtask

   // New attribute settings once the block is idle, then random traffic under them.
   task automatic run_attribute_phase(input logic [tcce_pkg::ATTR_W-1:0] text_value,
                                      input logic [tcce_pkg::ATTR_W-1:0] fill_value,
                                      input int count);
      wait_drained();
      write_register(tcce_pkg::CSR_TEXT_ATTR, text_value);
      write_register(tcce_pkg::CSR_SCROLL_ATTR, fill_value);
      run_random_traffic(count);
   endtask

   initial begin : main_sequence
      cur_col   = 0;
      cur_row   = 0;
      text_attr = tcce_pkg::ATTR_RESET;
      fill_attr = tcce_pkg::ATTR_RESET;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_clear_and_read();
      test_put_characters();
      test_unused_command();
      test_response_hold_off();

      // A long stretch with no idling on either side, still at the reset attributes.
      idle_pct = 0;
      run_random_traffic(60);
      idle_pct = IDLE_PCT;

      run_attribute_phase(8'h00, 8'hFF, 80);
      run_attribute_phase(8'hFF, 8'h00, 80);
      run_attribute_phase(tcce_pkg::ATTR_W'($urandom_range(255)),
                          tcce_pkg::ATTR_W'($urandom_range(255)), 80);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
